[sv/rubi_pkg.sv]
// Shared constants, types and helpers for the unit box intersection block.
// No dependencies; imported by every module of the block.
package rubi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_FACES     = 6;
	localparam int NUM_AXES      = 3;
	// Quotient bits kept by the divider; the distance saturates at 2^31-1.
	localparam int QBITS         = 31;
	// One capture stage, one range-check stage, one stage per quotient bit.
	localparam int DIV_LAT       = QBITS + 2;
	localparam logic [15:0] EPS_RESET = 16'd7;

	localparam logic signed [64:0] UV_MIN65 = -65'sd131072;
	localparam logic signed [64:0] UV_MAX65 = 65'sd131071;

	typedef struct packed {
		logic               hit;
		logic [QBITS-1:0]   tdist;
		logic signed [17:0] u;
		logic signed [17:0] v;
	} face_res_t;

	function automatic logic signed [17:0] sat_uv(input logic signed [64:0] x);
		logic signed [64:0] r;
		r = x;
		if (x < UV_MIN65) r = UV_MIN65;
		else if (x > UV_MAX65) r = UV_MAX65;
		return r[17:0];
	endfunction

endpackage

[sv/rubi_div.sv]
// Pipelined restoring divider with saturation, one quotient bit per stage.
// Depends on rubi_pkg.
module rubi_div #(
	parameter int FRAC_BITS = rubi_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [32+FRAC_BITS:0]  num,
	input  logic [31:0]            den,
	output logic [rubi_pkg::QBITS-1:0] quo
);
	import rubi_pkg::*;

	localparam int NW = 33 + FRAC_BITS;
	localparam int HW = NW - QBITS;

	logic [NW-1:0]    n0_s;
	logic [31:0]      d0_s;
	logic [NW-1:0]    n_s   [0:QBITS];
	logic [31:0]      d_s   [0:QBITS];
	logic [31:0]      rem_s [0:QBITS];
	logic [QBITS-1:0] q_s   [0:QBITS];
	logic             ovf_s [0:QBITS];
	logic [HW-1:0]    hi;

	assign hi = n0_s[NW-1:QBITS];

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s     <= num;
			d0_s     <= den;
			n_s[0]   <= n0_s;
			d_s[0]   <= d0_s;
			ovf_s[0] <= 34'(hi) >= 34'(d0_s);
			rem_s[0] <= 32'(hi);
			q_s[0]   <= '0;
		end
	end

	for (genvar j = 1; j <= QBITS; j++) begin : g_step
		logic [32:0] trial;
		logic        ge;
		logic [32:0] diff;
		assign trial = {rem_s[j-1], n_s[j-1][QBITS-j]};
		assign ge    = trial >= {1'b0, d_s[j-1]};
		assign diff  = trial - {1'b0, d_s[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[j]   <= n_s[j-1];
				d_s[j]   <= d_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				rem_s[j] <= ge ? diff[31:0] : trial[31:0];
				q_s[j]   <= {q_s[j-1][QBITS-2:0], ge};
			end
		end
	end

	assign quo = ovf_s[QBITS] ? '1 : q_s[QBITS];

endmodule

[sv/rubi_face.sv]
// Per-face hit point: scale the other two axes by t, bounds test, face coordinates.
// Depends on rubi_pkg.
module rubi_face #(
	parameter int FRAC_BITS = rubi_pkg::FRAC_BITS_DEF,
	parameter int AXIS      = 0
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       keep_in,
	input  logic [rubi_pkg::QBITS-1:0] ts_in,
	input  logic signed [31:0]         o_a,
	input  logic signed [31:0]         o_b,
	input  logic signed [31:0]         d_a,
	input  logic signed [31:0]         d_b,
	input  logic [15:0]                eps,
	output rubi_pkg::face_res_t        res
);
	import rubi_pkg::*;

	localparam logic signed [64:0] ONE = 65'sd1 <<< FRAC_BITS;

	logic signed [63:0] prod_a_s1, prod_b_s1;
	logic signed [31:0] o_a_s1, o_b_s1;
	logic               keep_s1;
	logic [QBITS-1:0]   ts_s1;
	logic signed [63:0] tss;
	logic signed [63:0] sa, sb;
	logic signed [64:0] pa, pb, mb, lim, uu, vv;
	logic               in_a, in_b;
	face_res_t          res_s2;

	assign tss = 64'($signed({1'b0, ts_in}));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1 <= 64'(d_a) * tss;
			prod_b_s1 <= 64'(d_b) * tss;
			o_a_s1    <= o_a;
			o_b_s1    <= o_b;
			keep_s1   <= keep_in;
			ts_s1     <= ts_in;
		end
	end

	always_comb begin
		sa   = prod_a_s1 >>> FRAC_BITS;
		sb   = prod_b_s1 >>> FRAC_BITS;
		pa   = 65'(o_a_s1) + 65'(sa);
		pb   = 65'(o_b_s1) + 65'(sb);
		mb   = 65'(o_b_s1) - 65'(sb);
		lim  = ONE + $signed(65'(eps));
		in_a = (pa >= -lim) && (pa <= lim);
		in_b = (pb >= -lim) && (pb <= lim);
		case (AXIS)
			0:       begin uu = pb; vv = pa; end
			1:       begin uu = mb; vv = pa; end
			default: begin uu = pa; vv = mb; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.hit   <= keep_s1 & in_a & in_b;
			res_s2.tdist <= ts_s1;
			res_s2.u     <= sat_uv(uu);
			res_s2.v     <= sat_uv(vv);
		end
	end

	assign res = res_s2;

endmodule

[sv/rubi_ser.sv]
// Result serializer: emits kept faces of one ray in face order, or one miss word.
// Depends on rubi_pkg.
module rubi_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_vld,
	input  rubi_pkg::face_res_t res [rubi_pkg::NUM_FACES],
	output logic                adv,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit_valid,
	output logic [30:0]         hit_distance,
	output logic [2:0]          face_index,
	output logic signed [17:0]  tex_u,
	output logic signed [17:0]  tex_v,
	output logic                last_result
);
	import rubi_pkg::*;

	logic                 pend_q;
	logic [NUM_FACES-1:0] mask_q;
	face_res_t            rec_q [NUM_FACES];
	logic [NUM_FACES-1:0] sel_oh, rest, hits;
	logic [2:0]           sel;
	logic                 emit, last, found;

	always_comb begin
		sel    = '0;
		sel_oh = '0;
		found  = 1'b0;
		for (int i = 0; i < NUM_FACES; i++) begin
			hits[i] = res[i].hit;
			if (!found && mask_q[i]) begin
				found     = 1'b1;
				sel       = 3'(i);
				sel_oh[i] = 1'b1;
			end
		end
		rest = mask_q & ~sel_oh;
		last = rest == '0;
		emit = pend_q && (!out_valid || out_ready);
		adv  = !pend_q || (emit && last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			mask_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			// A new ray replaces the finished one; otherwise drop the face just sent.
			if (adv) begin
				pend_q <= load_vld;
				mask_q <= load_vld ? hits : '0;
			end else if (emit) begin
				mask_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_FACES; i++) rec_q[i] <= res[i];
		end
		if (emit) begin
			last_result <= last;
			if (mask_q == '0) begin
				hit_valid    <= 1'b0;
				hit_distance <= '0;
				face_index   <= '0;
				tex_u        <= '0;
				tex_v        <= '0;
			end else begin
				hit_valid    <= 1'b1;
				hit_distance <= rec_q[sel].tdist;
				face_index   <= sel;
				tex_u        <= rec_q[sel].u;
				tex_v        <= rec_q[sel].v;
			end
		end
	end

	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_valid |-> last_result)
		else $error("miss word without last mark");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_valid |-> hit_distance == '0 && face_index == '0)
		else $error("miss word carries nonzero fields");
	a_face_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_valid |-> face_index < 3'(NUM_FACES))
		else $error("face index out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !emit |=> pend_q && $stable(mask_q))
		else $error("pending ray lost while stalled");

endmodule

[sv/ray_unit_box_intersection.sv]
// Top level of the ray against unit box [-1,1]^3 intersection block.
// Depends on rubi_pkg, rubi_div, rubi_face and rubi_ser.
//
// One ray word (origin and direction, signed fixed point) yields one output word
// for every box face it hits at t >= epsilon with the hit point inside the box
// widened by epsilon, in face order +x,-x,+y,-y,+z,-z, the final one marked by
// last_result; a ray that hits nothing yields a single word with hit_valid low.
// All six faces are worked in parallel: an input register, a six-lane pipelined
// divider with one quotient bit per stage (33 stages), two stages of multiply and
// bounds check, then a serializer and the output register. The serializer sets
// the throughput: a ray holds it until all its words are sent, one per kept face
// or a single miss word, and the pipeline advances only while no ray is pending
// or as the last word of one is sent. Stalls on the output freeze the whole
// pipeline without losing or repeating anything. epsilon is written through
// cfg_we and cfg_wdata and resets to 7; write it only while the block is idle.
module ray_unit_box_intersection #(
	parameter int FRAC_BITS = rubi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit_valid,
	output logic [30:0]        hit_distance,
	output logic [2:0]         face_index,
	output logic signed [17:0] tex_u,
	output logic signed [17:0] tex_v,
	output logic               last_result
);
	import rubi_pkg::*;

	localparam int NW = 33 + FRAC_BITS;
	localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;

	logic [15:0]        eps_q;
	logic               en;
	logic               vld_s1;
	logic signed [31:0] o_s1 [NUM_AXES];
	logic signed [31:0] d_s1 [NUM_AXES];

	// Side data that travels alongside the divider lanes.
	logic                 vld_s2 [DIV_LAT];
	logic signed [31:0]   o_s2   [DIV_LAT][NUM_AXES];
	logic signed [31:0]   d_s2   [DIV_LAT][NUM_AXES];
	logic [NUM_FACES-1:0] neg_s2 [DIV_LAT];
	logic [NUM_FACES-1:0] dz_s2  [DIV_LAT];

	logic                 vld_s3, vld_s4;
	logic [NUM_FACES-1:0] neg_c, dz_c;
	face_res_t            res [NUM_FACES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eps_q <= EPS_RESET;
		else if (cfg_we) eps_q <= cfg_wdata;
	end

	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) vld_s2[i] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2[0] <= vld_s1;
			for (int i = 1; i < DIV_LAT; i++) vld_s2[i] <= vld_s2[i-1];
			vld_s3    <= vld_s2[DIV_LAT-1];
			vld_s4    <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1[0] <= origin_x;
			o_s1[1] <= origin_y;
			o_s1[2] <= origin_z;
			d_s1[0] <= dir_x;
			d_s1[1] <= dir_y;
			d_s1[2] <= dir_z;
			o_s2[0]   <= o_s1;
			d_s2[0]   <= d_s1;
			neg_s2[0] <= neg_c;
			dz_s2[0]  <= dz_c;
			for (int i = 1; i < DIV_LAT; i++) begin
				o_s2[i]   <= o_s2[i-1];
				d_s2[i]   <= d_s2[i-1];
				neg_s2[i] <= neg_s2[i-1];
				dz_s2[i]  <= dz_s2[i-1];
			end
		end
	end

	for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
		localparam int AX   = f / 2;
		localparam int AIDX = (AX == 0) ? 1 : 0;
		localparam int BIDX = (AX == 2) ? 1 : 2;

		logic signed [32:0] pmo;
		logic [32:0]        mag;
		logic [NW-1:0]      num;
		logic [31:0]        den;
		logic [QBITS-1:0]   quo;
		logic               keep;

		// Numerator (plane - o) * ONE and divisor, both as magnitudes.
		assign pmo   = ((f % 2 == 1) ? -ONE33 : ONE33) - 33'(o_s1[AX]);
		assign mag   = pmo[32] ? 33'(-pmo) : 33'(pmo);
		assign num   = {mag, {FRAC_BITS{1'b0}}};
		assign den   = d_s1[AX][31] ? 32'(-d_s1[AX]) : 32'(d_s1[AX]);
		assign neg_c[f] = pmo[32] ^ d_s1[AX][31];
		assign dz_c[f]  = d_s1[AX] == '0;

		rubi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.en  (en),
			.num (num),
			.den (den),
			.quo (quo)
		);

		// A negative nonzero quotient means the plane lies behind the origin.
		assign keep = vld_s2[DIV_LAT-1] && !dz_s2[DIV_LAT-1][f]
			&& !(neg_s2[DIV_LAT-1][f] && quo != '0)
			&& (quo >= QBITS'(eps_q));

		rubi_face #(.FRAC_BITS(FRAC_BITS), .AXIS(AX)) u_face (
			.clk     (clk),
			.en      (en),
			.keep_in (keep),
			.ts_in   (quo),
			.o_a     (o_s2[DIV_LAT-1][AIDX]),
			.o_b     (o_s2[DIV_LAT-1][BIDX]),
			.d_a     (d_s2[DIV_LAT-1][AIDX]),
			.d_b     (d_s2[DIV_LAT-1][BIDX]),
			.eps     (eps_q),
			.res     (res[f])
		);
	end

	rubi_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_vld     (vld_s4),
		.res          (res),
		.adv          (en),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit_valid    (hit_valid),
		.hit_distance (hit_distance),
		.face_index   (face_index),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.last_result  (last_result)
	);

endmodule
